// File: hdl/hmef_pkg.sv
// ----------------------------------------------------------------------------
// hmef_pkg
// Shared types and constants of the hit multiplicity event filter.
// ----------------------------------------------------------------------------
package hmef_pkg;

    localparam int MAX_STRINGS        = 128;
    localparam int MODULES_PER_STRING = 64;

    localparam int STR_W    = $clog2(MAX_STRINGS);
    localparam int TANK_SLOTS = 32;
    localparam int TANK_W   = $clog2(TANK_SLOTS);
    localparam int SLOT_BASE   = 59;
    localparam int SLOT_OFFSET = 29;

    localparam int COUNT_W     = 14;
    localparam int MAXC_W      = 15;
    localparam int STR_HITS_W  = $clog2(MAX_STRINGS + 1);
    localparam int TANK_HITS_W = $clog2(MAX_STRINGS * TANK_SLOTS + 1);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH   = 3'd4;

    typedef enum logic [1:0] {
        MODE_MODULES  = 2'd0,
        MODE_STRINGS  = 2'd1,
        MODE_TANKS    = 2'd2,
        MODE_STATIONS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_IN_ICE  = 2'd0,
        KIND_SURFACE = 2'd1,
        KIND_OTHER   = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // per-string bitmap entry
    typedef struct packed {
        logic [TANK_SLOTS-1:0] tank_seen;
        logic                  station_seen;
        logic                  string_seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: hdl/hmef_ram.sv
// ----------------------------------------------------------------------------
// hmef_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module hmef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/hit_multiplicity_event_filter.sv
// ----------------------------------------------------------------------------
// hit_multiplicity_event_filter
// Counts hit modules and distinct strings, tanks and stations per event and
// checks the selected count against a configurable window.
// ----------------------------------------------------------------------------
// The filter takes one module word per clock while not stalled. Per-string marks
// live in a 128 x 34 RAM (string, station and 32 tank-slot bits); a word reads its
// entry on acceptance and writes it back when it leaves stage 1, with the previous
// write forwarded when both touch the same string. Each entry has a valid flop;
// all are cleared together at the end of an event, so no clearing pass is
// needed. The result of the word flagged last is registered from stage 1 into
// the output register. Input stalls only when a last word meets an output
// register that still holds an untaken result.
module hit_multiplicity_event_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [hmef_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hmef_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input words
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [6:0] string_number, [12:7] module_number, [13] has_launches,
    // [14] readout_missing, [15] zero
    input  logic [15:0]                       i_s_axis_tdata,
    // [0] module_valid, [2:1] module_kind
    input  logic [2:0]                        i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    // result words
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] accept, [14:1] selected_count, [15] geometry_missing
    output logic [15:0]                       o_m_axis_tdata
);

    localparam int STR_W  = hmef_pkg::STR_W;
    localparam int TANK_W = hmef_pkg::TANK_W;
    localparam int CNT_W  = hmef_pkg::COUNT_W;
    localparam int SH_W   = hmef_pkg::STR_HITS_W;
    localparam int TH_W   = hmef_pkg::TANK_HITS_W;

    // configuration registers
    hmef_pkg::t_mode                r_mode;
    logic [CNT_W-1:0]               r_min;
    logic [hmef_pkg::MAXC_W-1:0]    r_max;
    logic [127:0]                   r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hmef_pkg::MODE_MODULES;
            r_min  <= '0;
            r_max  <= '1;
            r_mask <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hmef_pkg::REG_COUNT_MODE: r_mode <= hmef_pkg::t_mode'(i_cfg_wdata[1:0]);
                hmef_pkg::REG_MIN_COUNT:  r_min  <= i_cfg_wdata[CNT_W-1:0];
                hmef_pkg::REG_MAX_COUNT:  r_max  <= i_cfg_wdata[hmef_pkg::MAXC_W-1:0];
                hmef_pkg::REG_MASK_LOW:   r_mask[63:0]   <= i_cfg_wdata;
                hmef_pkg::REG_MASK_HIGH:  r_mask[127:64] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input decode
    logic                 in_valid;
    logic [6:0]           in_str;
    logic [5:0]           in_mod;
    hmef_pkg::t_kind      in_kind;
    logic                 in_launch;
    logic                 in_missing;
    logic                 in_take;
    logic [TANK_W-1:0]    in_tbit;
    logic                 s_acc;

    assign in_valid   = i_s_axis_tuser[0];
    assign in_kind    = hmef_pkg::t_kind'(i_s_axis_tuser[2:1]);
    assign in_str     = i_s_axis_tdata[6:0];
    assign in_mod     = i_s_axis_tdata[12:7];
    assign in_launch  = i_s_axis_tdata[13];
    assign in_missing = i_s_axis_tdata[14];

    assign in_take = !in_missing && in_valid && in_launch
                     && ({1'b0, in_str} < 8'(hmef_pkg::MAX_STRINGS))
                     && ({1'b0, in_mod} < 7'(hmef_pkg::MODULES_PER_STRING))
                     && r_mask[in_str];

    // tank slot (module - 59) / 2 toward zero, offset into 0..31
    always_comb begin
        if ({1'b0, in_mod} >= 7'(hmef_pkg::SLOT_BASE)) begin
            in_tbit = TANK_W'(7'(hmef_pkg::SLOT_OFFSET)
                      + (({1'b0, in_mod} - 7'(hmef_pkg::SLOT_BASE)) >> 1));
        end else begin
            in_tbit = TANK_W'(7'(hmef_pkg::SLOT_OFFSET)
                      - ((7'(hmef_pkg::SLOT_BASE) - {1'b0, in_mod}) >> 1));
        end
    end

    // stage 1 registers
    logic                 r_s1_vld;
    logic                 r_s1_take;
    logic                 r_s1_missing;
    logic                 r_s1_last;
    hmef_pkg::t_kind      r_s1_kind;
    logic [STR_W-1:0]     r_s1_addr;
    logic [TANK_W-1:0]    r_s1_tbit;

    logic                 s1_adv;
    logic                 out_free;

    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign s1_adv          = r_s1_vld && (!r_s1_last || out_free);
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_take    <= in_take;
            r_s1_missing <= in_missing;
            r_s1_last    <= i_s_axis_tlast;
            r_s1_kind    <= in_kind;
            r_s1_addr    <= in_str[STR_W-1:0];
            r_s1_tbit    <= in_tbit;
        end
    end

    // bitmap memory
    logic                          wr_en;
    hmef_pkg::t_entry              ram_rdata;
    hmef_pkg::t_entry              cur;
    hmef_pkg::t_entry              n_entry;

    hmef_ram #(
        .WIDTH (hmef_pkg::ENTRY_W),
        .DEPTH (hmef_pkg::MAX_STRINGS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (n_entry),
        .i_re    (s_acc),
        .i_raddr (in_str[STR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    logic [hmef_pkg::MAX_STRINGS-1:0] r_valid;
    logic                             r_fwd_vld;
    logic [STR_W-1:0]                 r_fwd_addr;
    hmef_pkg::t_entry                 r_fwd_data;
    logic                             fwd_hit;

    assign fwd_hit = r_fwd_vld && (r_fwd_addr == r_s1_addr);

    always_comb begin
        if (fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_valid[r_s1_addr]) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end
    end

    // event counters
    logic [CNT_W-1:0]   r_mod_hits;
    logic [SH_W-1:0]    r_str_hits;
    logic [SH_W-1:0]    r_sta_hits;
    logic [TH_W-1:0]    r_tank_hits;
    logic               r_miss_flag;
    logic               r_rej_flag;

    logic               is_ice;
    logic               is_surf;
    logic               new_str;
    logic               new_sta;
    logic               new_tank;
    logic [CNT_W-1:0]   n_mod_hits;
    logic [SH_W-1:0]    n_str_hits;
    logic [SH_W-1:0]    n_sta_hits;
    logic [TH_W-1:0]    n_tank_hits;
    logic               n_miss_flag;
    logic               n_rej_flag;
    logic [CNT_W-1:0]   sel_count;
    logic               pass;
    logic [15:0]        result;

    assign is_ice   = r_s1_take && (r_s1_kind == hmef_pkg::KIND_IN_ICE);
    assign is_surf  = r_s1_take && (r_s1_kind == hmef_pkg::KIND_SURFACE);
    assign new_str  = is_ice && !cur.string_seen;
    assign new_sta  = is_surf && !cur.station_seen;
    assign new_tank = is_surf && !cur.tank_seen[r_s1_tbit];
    assign wr_en    = s1_adv && (is_ice || is_surf);

    always_comb begin
        n_entry = cur;
        if (is_ice) begin
            n_entry.string_seen = 1'b1;
        end
        if (is_surf) begin
            n_entry.station_seen          = 1'b1;
            n_entry.tank_seen[r_s1_tbit]  = 1'b1;
        end
    end

    always_comb begin
        n_mod_hits  = r_mod_hits;
        if (r_s1_take && (r_mod_hits != hmef_pkg::COUNT_LIMIT)) begin
            n_mod_hits = r_mod_hits + 1'b1;
        end
        n_str_hits  = r_str_hits + SH_W'(new_str);
        n_sta_hits  = r_sta_hits + SH_W'(new_sta);
        n_tank_hits = r_tank_hits + TH_W'(new_tank);
        n_miss_flag = r_miss_flag || (r_s1_take && (r_s1_kind == hmef_pkg::KIND_NONE));
        n_rej_flag  = r_rej_flag || r_s1_missing;
    end

    always_comb begin
        case (r_mode)
            hmef_pkg::MODE_MODULES:  sel_count = n_mod_hits;
            hmef_pkg::MODE_STRINGS:  sel_count = CNT_W'(n_str_hits);
            hmef_pkg::MODE_TANKS:    sel_count = CNT_W'(n_tank_hits);
            hmef_pkg::MODE_STATIONS: sel_count = CNT_W'(n_sta_hits);
            default:                 sel_count = n_mod_hits;
        endcase
        pass = (sel_count >= r_min)
               && (r_max[hmef_pkg::MAXC_W-1] || (sel_count <= r_max[CNT_W-1:0]));
        if (n_rej_flag) begin
            result = '0;
        end else begin
            result = {n_miss_flag, sel_count, pass};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fwd_vld   <= 1'b0;
            r_mod_hits  <= '0;
            r_str_hits  <= '0;
            r_sta_hits  <= '0;
            r_tank_hits <= '0;
            r_miss_flag <= 1'b0;
            r_rej_flag  <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_valid     <= '0;
                r_fwd_vld   <= 1'b0;
                r_mod_hits  <= '0;
                r_str_hits  <= '0;
                r_sta_hits  <= '0;
                r_tank_hits <= '0;
                r_miss_flag <= 1'b0;
                r_rej_flag  <= 1'b0;
            end else begin
                if (wr_en) begin
                    r_valid[r_s1_addr] <= 1'b1;
                    r_fwd_vld          <= 1'b1;
                end
                r_mod_hits  <= n_mod_hits;
                r_str_hits  <= n_str_hits;
                r_sta_hits  <= n_sta_hits;
                r_tank_hits <= n_tank_hits;
                r_miss_flag <= n_miss_flag;
                r_rej_flag  <= n_rej_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_entry;
        end
    end

    // result register
    logic        r_out_vld;
    logic [15:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_data <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_last |=> (r_mod_hits == '0) && (r_tank_hits == '0)
                                && (r_str_hits == '0) && !r_rej_flag)
        else $error("event state not cleared after decision");

    a_marks_le_modules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_str_hits) + CNT_W'(r_tank_hits)) <= r_mod_hits)
        else $error("more distinct marks than hit modules");

    a_station_le_tank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_sta_hits) <= CNT_W'(r_tank_hits))
        else $error("station count exceeds tank count");

    a_fwd_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_vld |-> r_valid[r_fwd_addr])
        else $error("forwarded entry not marked valid");

    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |-> !wr_en && !s_acc)
        else $error("memory or input moved while stage stalled");

endmodule

// File: bench/tb_hit_multiplicity_event_filter.sv
// ----------------------------------------------------------------------------
// tb_hit_multiplicity_event_filter
// Self-checking bench for the hit multiplicity event filter. A behavioral
// predictor tracks the hit, string, station and tank marks of each event and
// queues the decision for every word flagged last. Results are compared field
// by field against the queue. Covers the reset settings, every count mode,
// window extremes, string masks, random events with both sides idling, a long
// output stall and one long event.
// ----------------------------------------------------------------------------
module tb_hit_multiplicity_event_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES   = 600000;
    localparam int IDLE_PCT       = 22;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int LONG_WORDS     = 120;
    localparam int RANDOM_WORDS   = 450;

    typedef struct {
        logic            valid;
        logic [6:0]      str_no;
        logic [5:0]      mod_no;
        hmef_pkg::t_kind kind;
        logic            launch;
        logic            no_readout;
        logic            last;
    } t_module_word;

    typedef struct {
        logic        accept;
        logic [13:0] count;
        logic        geo_missing;
    } t_decision;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [hmef_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [hmef_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [6:0] string_number, [12:7] module_number, [13] has_launches,
    // [14] readout_missing, [15] zero
    logic [15:0] i_s_axis_tdata = '0;
    // [0] module_valid, [2:1] module_kind
    logic [2:0]  i_s_axis_tuser = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [0] accept, [14:1] selected_count, [15] geometry_missing
    logic [15:0] o_m_axis_tdata;

    hit_multiplicity_event_filter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of registers and event state
    hmef_pkg::t_mode cfg_mode;
    logic [13:0] cfg_min;
    logic [14:0] cfg_max;
    logic [63:0] cfg_mask_lo;
    logic [63:0] cfg_mask_hi;

    logic [13:0]  ev_modules;
    logic [127:0] ev_strings;
    logic [127:0] ev_stations;
    logic [31:0]  ev_tanks [hmef_pkg::MAX_STRINGS];
    int           ev_string_cnt;
    int           ev_station_cnt;
    int           ev_tank_cnt;
    logic         ev_geo_missing;
    logic         ev_rejected;

    t_decision decision_q [$];

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold_req = 0;
    int rx_hold_served = 0;

    int words_sent = 0;
    int results_seen = 0;
    int accepts = 0;
    int rejected_events = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int cycles = 0;

    task automatic clear_event_state();
        ev_modules = '0;
        ev_strings = '0;
        ev_stations = '0;
        for (int i = 0; i < hmef_pkg::MAX_STRINGS; i++) ev_tanks[i] = '0;
        ev_string_cnt = 0;
        ev_station_cnt = 0;
        ev_tank_cnt = 0;
        ev_geo_missing = 1'b0;
        ev_rejected = 1'b0;
    endtask

    function automatic logic [4:0] tank_slot_bit(logic [5:0] m);
        int d;
        d = int'(m) - hmef_pkg::SLOT_BASE;
        return 5'((d / 2) + hmef_pkg::SLOT_OFFSET);
    endfunction

    task automatic count_module_word(t_module_word w);
        t_decision  d;
        int         cnt;
        logic       en;
        logic [4:0] tb;
        if (w.no_readout) begin
            ev_rejected = 1'b1;
        end else if (w.valid && w.launch) begin
            en = w.str_no[6] ? cfg_mask_hi[w.str_no[5:0]] : cfg_mask_lo[w.str_no[5:0]];
            if (en) begin
                if (ev_modules != hmef_pkg::COUNT_LIMIT) ev_modules++;
                case (w.kind)
                    hmef_pkg::KIND_IN_ICE: begin
                        if (!ev_strings[w.str_no]) begin
                            ev_strings[w.str_no] = 1'b1;
                            ev_string_cnt++;
                        end
                    end
                    hmef_pkg::KIND_SURFACE: begin
                        tb = tank_slot_bit(w.mod_no);
                        if (!ev_stations[w.str_no]) begin
                            ev_stations[w.str_no] = 1'b1;
                            ev_station_cnt++;
                        end
                        if (!ev_tanks[w.str_no][tb]) begin
                            ev_tanks[w.str_no][tb] = 1'b1;
                            ev_tank_cnt++;
                        end
                    end
                    hmef_pkg::KIND_NONE: ev_geo_missing = 1'b1;
                    default: ;
                endcase
            end
        end
        if (w.last) begin
            case (cfg_mode)
                hmef_pkg::MODE_MODULES: cnt = ev_modules;
                hmef_pkg::MODE_STRINGS: cnt = ev_string_cnt;
                hmef_pkg::MODE_TANKS:   cnt = ev_tank_cnt;
                default:                cnt = ev_station_cnt;
            endcase
            if (ev_rejected) begin
                d.accept = 1'b0;
                d.count = '0;
                d.geo_missing = 1'b0;
                rejected_events++;
            end else begin
                d.accept = (cnt >= cfg_min) && !(!cfg_max[14] && cnt > cfg_max);
                d.count = cnt[13:0];
                d.geo_missing = ev_geo_missing;
            end
            decision_q.push_back(d);
            clear_event_state();
        end
    endtask

    task automatic send_word(t_module_word w);
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {1'b0, w.no_readout, w.launch, w.mod_no, w.str_no};
        i_s_axis_tuser <= {w.kind, w.valid};
        i_s_axis_tlast <= w.last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        count_module_word(w);
        words_sent++;
    endtask

    function automatic t_module_word mw(bit v, int s, int m, hmef_pkg::t_kind k, bit l,
                                        bit r, bit last);
        t_module_word w;
        w.valid = v;
        w.str_no = 7'(s);
        w.mod_no = 6'(m);
        w.kind = k;
        w.launch = l;
        w.no_readout = r;
        w.last = last;
        return w;
    endfunction

    // drain results, then allow the pipeline to empty before touching registers
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decision_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [hmef_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hmef_pkg::REG_COUNT_MODE: cfg_mode = hmef_pkg::t_mode'(data[1:0]);
            hmef_pkg::REG_MIN_COUNT:  cfg_min = data[13:0];
            hmef_pkg::REG_MAX_COUNT:  cfg_max = data[14:0];
            hmef_pkg::REG_MASK_LOW:   cfg_mask_lo = data;
            hmef_pkg::REG_MASK_HIGH:  cfg_mask_hi = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(hmef_pkg::t_mode mode, logic [13:0] mn, logic [14:0] mx,
                              logic [63:0] lo, logic [63:0] hi);
        settle();
        write_reg(hmef_pkg::REG_COUNT_MODE, 64'(mode));
        write_reg(hmef_pkg::REG_MIN_COUNT, 64'(mn));
        write_reg(hmef_pkg::REG_MAX_COUNT, 64'(mx));
        write_reg(hmef_pkg::REG_MASK_LOW, lo);
        write_reg(hmef_pkg::REG_MASK_HIGH, hi);
    endtask

    // mostly well-formed events, half their words on a few strings; some are pure noise
    task automatic random_event(int len);
        t_module_word w;
        logic [6:0]   pool [4];
        bit           noisy;
        int           k;
        noisy = ($urandom_range(99) < 10);
        for (int i = 0; i < 4; i++) pool[i] = 7'($urandom_range(127));
        for (int i = 0; i < len; i++) begin
            k = $urandom_range(99);
            w.valid = noisy ? 1'($urandom) : ($urandom_range(99) < 92);
            w.str_no = $urandom_range(1) ? pool[$urandom_range(3)] : 7'($urandom_range(127));
            if (noisy) w.kind = hmef_pkg::t_kind'($urandom_range(3));
            else if (k < 40) w.kind = hmef_pkg::KIND_IN_ICE;
            else if (k < 75) w.kind = hmef_pkg::KIND_SURFACE;
            else if (k < 88) w.kind = hmef_pkg::KIND_OTHER;
            else w.kind = hmef_pkg::KIND_NONE;
            w.mod_no = (w.kind == hmef_pkg::KIND_SURFACE && $urandom_range(1)) ?
                       6'($urandom_range(63, 54)) : 6'($urandom_range(63));
            w.launch = noisy ? 1'($urandom) : ($urandom_range(99) < 85);
            w.no_readout = ($urandom_range(99) < (noisy ? 20 : 2));
            w.last = (i == len - 1);
            send_word(w);
        end
    endtask

    function automatic int event_len();
        return ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
    endfunction

    function automatic logic [63:0] dense_mask();
        return ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    endfunction

    // reset register values, every kind, slot edges, repeats and end markers
    task automatic test_directed();
        send_word(mw(1, 0,   0,  hmef_pkg::KIND_IN_ICE,  1, 0, 0));
        send_word(mw(1, 127, 63, hmef_pkg::KIND_IN_ICE,  1, 0, 0));
        send_word(mw(1, 127, 5,  hmef_pkg::KIND_IN_ICE,  1, 0, 0));
        send_word(mw(1, 5,   59, hmef_pkg::KIND_SURFACE, 1, 0, 0));
        send_word(mw(1, 5,   60, hmef_pkg::KIND_SURFACE, 1, 0, 0));
        send_word(mw(1, 5,   0,  hmef_pkg::KIND_SURFACE, 1, 0, 0));
        send_word(mw(1, 5,   63, hmef_pkg::KIND_SURFACE, 1, 0, 0));
        send_word(mw(1, 64,  58, hmef_pkg::KIND_SURFACE, 1, 0, 0));
        send_word(mw(1, 9,   1,  hmef_pkg::KIND_OTHER,   1, 0, 0));
        send_word(mw(1, 10,  1,  hmef_pkg::KIND_NONE,    1, 0, 0));
        send_word(mw(1, 11,  1,  hmef_pkg::KIND_IN_ICE,  0, 0, 0));
        send_word(mw(0, 12,  1,  hmef_pkg::KIND_IN_ICE,  1, 0, 0));
        send_word(mw(1, 0,   0,  hmef_pkg::KIND_IN_ICE,  1, 0, 0));
        send_word(mw(0, 0,   0,  hmef_pkg::KIND_IN_ICE,  0, 0, 1));
        // missing readout mid-event
        send_word(mw(1, 3,   3,  hmef_pkg::KIND_IN_ICE,  1, 0, 0));
        send_word(mw(0, 0,   0,  hmef_pkg::KIND_IN_ICE,  0, 1, 0));
        send_word(mw(1, 4,   4,  hmef_pkg::KIND_NONE,    1, 0, 1));
        // bare end marker only
        send_word(mw(0, 0,   0,  hmef_pkg::KIND_IN_ICE,  0, 0, 1));
        // missing readout on the last word itself
        send_word(mw(1, 2,   2,  hmef_pkg::KIND_SURFACE, 1, 1, 1));
        send_word(mw(1, 127, 63, hmef_pkg::KIND_NONE,    1, 0, 1));
    endtask

    task automatic test_windows();
        logic [63:0] ones;
        ones = '1;
        set_config(hmef_pkg::MODE_MODULES, 0, 15'h7fff, ones, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_STRINGS, 2, 5, ones, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_TANKS, 3, 3, ones, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_STATIONS, 0, 0, ones, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_MODULES, 8192, 8192, ones, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_STRINGS, 0, 15'h4000, ones, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_TANKS, 1, 15'h7fff, '0, '0);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_STATIONS, 1, 15'h7fff, ones, '0);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_MODULES, 1, 6, '0, ones);
        repeat (8) random_event(event_len());
        set_config(hmef_pkg::MODE_STRINGS, 0, 8192, dense_mask(), dense_mask());
        repeat (8) random_event(event_len());
    endtask

    task automatic test_random();
        int start;
        logic [14:0] mx;
        start = words_sent;
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        repeat (20) random_event(event_len());
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        while (words_sent - start < RANDOM_WORDS) begin
            mx = ($urandom_range(3) == 0) ? 15'h7fff : 15'($urandom_range(10));
            set_config(hmef_pkg::t_mode'($urandom_range(3)), 14'($urandom_range(6)), mx,
                       $urandom_range(4) ? dense_mask() : '1,
                       $urandom_range(4) ? dense_mask() : '1);
            repeat (20) random_event(event_len());
        end
    endtask

    // output held off while the sender keeps offering short events
    task automatic test_backpressure();
        set_config(hmef_pkg::MODE_STRINGS, 0, 15'h7fff, '1, '1);
        tx_quiet = 1'b1;
        rx_hold_req++;
        repeat (60) random_event($urandom_range(3, 1));
        tx_quiet = 1'b0;
    endtask

    // one long event sweeping strings 0 to 119 with the module count near the floor
    task automatic test_long_event();
        set_config(hmef_pkg::MODE_MODULES, 100, 15'h7fff, '1, '1);
        tx_quiet = 1'b1;
        for (int i = 0; i < LONG_WORDS; i++)
            send_word(mw(1, i % 128, i % 64, hmef_pkg::KIND_IN_ICE, 1, 0,
                         i == LONG_WORDS - 1));
        tx_quiet = 1'b0;
    endtask

    initial begin : rx_side
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != rx_hold_served) begin
                rx_hold_served = rx_hold_req;
                i_m_axis_tready <= 1'b0;
                for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge i_clk);
            end
            i_m_axis_tready <= rx_quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_decision d;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (decision_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h at cycle %0d", o_m_axis_tdata, cycles);
            end else begin
                d = decision_q.pop_front();
                results_seen++;
                if (o_m_axis_tdata[0]) accepts++;
                if (o_m_axis_tdata[0] !== d.accept || o_m_axis_tdata[14:1] !== d.count ||
                    o_m_axis_tdata[15] !== d.geo_missing) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d mismatch: exp accept %0d count %0d geo %0d,",
                                  " got %0d %0d %0d"},
                                 results_seen, d.accept, d.count, d.geo_missing,
                                 o_m_axis_tdata[0], o_m_axis_tdata[14:1], o_m_axis_tdata[15]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, decision_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        cfg_mode = hmef_pkg::MODE_MODULES;
        cfg_min = '0;
        cfg_max = 15'h7fff;
        cfg_mask_lo = '1;
        cfg_mask_hi = '1;
        clear_event_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_windows();
        test_random();
        test_backpressure();
        test_long_event();
        settle();
        $display("sent %0d words in %0d cycles with %0d register writes", words_sent, cycles,
                 reg_writes);
        $display("checked %0d decisions: %0d accepted, %0d rejected on missing readout, %0d bad",
                 results_seen, accepts, rejected_events, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: hit_multiplicity_event_filter.f
hdl/hmef_pkg.sv
hdl/hmef_ram.sv
hdl/hit_multiplicity_event_filter.sv
bench/tb_hit_multiplicity_event_filter.sv
